// ----- hw/rtl/bdar_pkg.sv -----
`timescale 1ns / 1ps

package bdar_pkg;

    localparam int PIN_W      = 4;
    localparam int KEY_W      = 3;
    localparam int RPT_W      = 6;
    localparam int STABLE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;

    // Hold delay before the first repeat after a key-down
    localparam logic [RPT_W-1:0] FIRST_HOLD_DELAY = 6'd25;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RPT_PERIOD      = 2'd0,
        REG_OUTPUT_ENABLE   = 2'd1,
        REG_STABLE_TICKS    = 2'd2,
        REG_ACTIVE_LEVEL    = 2'd3
    } t_cfg_reg;

    // Press codes of single buttons
    localparam logic [PIN_W-1:0] CODE_ENTER     = 4'h1;
    localparam logic [PIN_W-1:0] CODE_UP        = 4'h2;
    localparam logic [PIN_W-1:0] CODE_ATTENTION = 4'h4;
    localparam logic [PIN_W-1:0] CODE_DOWN      = 4'h8;

    localparam logic [KEY_W-1:0] KEY_NONE      = 3'd0;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 3'd1;
    localparam logic [KEY_W-1:0] KEY_UP        = 3'd2;
    localparam logic [KEY_W-1:0] KEY_ATTENTION = 3'd3;
    localparam logic [KEY_W-1:0] KEY_DOWN      = 3'd4;

    localparam logic EVT_KEY_DOWN = 1'b0;
    localparam logic EVT_HELD     = 1'b1;

    typedef struct packed {
        logic [RPT_W-1:0]    rpt_period;
        logic                output_enable;
        logic [STABLE_W-1:0] stable_ticks;
        logic                active_level;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key_code;
        logic             event_type;
    } t_event;

    function automatic logic [KEY_W-1:0] code_to_key(input logic [PIN_W-1:0] code);
        logic [KEY_W-1:0] key;
        case (code)
            CODE_ENTER:     key = KEY_ENTER;
            CODE_UP:        key = KEY_UP;
            CODE_ATTENTION: key = KEY_ATTENTION;
            CODE_DOWN:      key = KEY_DOWN;
            default:        key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

// ----- hw/rtl/bdar_cfg.sv -----
`timescale 1ns / 1ps

module bdar_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bdar_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output bdar_pkg::t_cfg                    o_cfg
);
    import bdar_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rpt_period      <= 6'd5;
            r_cfg.output_enable   <= 1'b1;
            r_cfg.stable_ticks    <= 8'd4;
            r_cfg.active_level    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_RPT_PERIOD:      r_cfg.rpt_period      <= i_cfg_wdata[RPT_W-1:0];
                REG_OUTPUT_ENABLE:   r_cfg.output_enable   <= i_cfg_wdata[0];
                REG_STABLE_TICKS:    r_cfg.stable_ticks    <= i_cfg_wdata[STABLE_W-1:0];
                REG_ACTIVE_LEVEL:    r_cfg.active_level    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/bdar_core.sv -----
`timescale 1ns / 1ps

module bdar_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [bdar_pkg::PIN_W-1:0]    i_pins,
    input  bdar_pkg::t_cfg                i_cfg,
    output bdar_pkg::t_event              o_event
);
    import bdar_pkg::*;

    logic                r_scanning,      n_scanning;
    logic [PIN_W-1:0]    r_sample_code,   n_sample_code;
    logic [STABLE_W-1:0] r_stable_count,  n_stable_count;
    logic [RPT_W-1:0]    r_hold_count,    n_hold_count;
    logic [PIN_W-1:0]    r_previous_code, n_previous_code;

    logic [PIN_W-1:0]    code;
    logic [STABLE_W-1:0] count_inc;
    logic                held;
    t_event              evt;

    assign code = i_cfg.active_level ? i_pins : ~i_pins;

    always_comb begin
        n_scanning      = r_scanning;
        n_sample_code   = r_sample_code;
        n_stable_count  = r_stable_count;
        n_hold_count    = r_hold_count;
        n_previous_code = r_previous_code;
        held            = (code == r_previous_code);
        count_inc       = (code != r_sample_code) ? '0 : r_stable_count + 8'd1;
        evt.valid       = 1'b0;
        evt.key_code    = code_to_key(code);
        evt.event_type  = held ? EVT_HELD : EVT_KEY_DOWN;

        if (i_step) begin
            if (!r_scanning) begin
                // first press wakes the scanner; this tick is not sampled
                if (code != '0) begin
                    n_scanning     = 1'b1;
                    n_stable_count = '0;
                    n_hold_count   = '0;
                end
            end else begin
                n_sample_code = code;
                if (count_inc == i_cfg.stable_ticks) begin
                    n_stable_count  = '0;
                    n_previous_code = code;
                    if (code == '0) begin
                        n_hold_count = '0;
                        n_scanning   = 1'b0;
                    end else if (r_hold_count == '0) begin
                        n_hold_count = held ? i_cfg.rpt_period : FIRST_HOLD_DELAY;
                        evt.valid    = i_cfg.output_enable;
                    end else begin
                        n_hold_count = r_hold_count - 6'd1;
                    end
                end else begin
                    n_stable_count = count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning      <= 1'b0;
            r_sample_code   <= '0;
            r_stable_count  <= '0;
            r_hold_count    <= '0;
            r_previous_code <= '0;
        end else begin
            r_scanning      <= n_scanning;
            r_sample_code   <= n_sample_code;
            r_stable_count  <= n_stable_count;
            r_hold_count    <= n_hold_count;
            r_previous_code <= n_previous_code;
        end
    end

    assign o_event = evt;

endmodule

// ----- hw/rtl/button_debounce_autorepeat.sv -----
`timescale 1ns / 1ps
// Timing: an accepted scan beat sits in the input register; its event (if any) is
// loaded into the result register when the slot is free; m_axis_tvalid follows it.
// Throughput: one scan beat per cycle; an event the master side does not take holds
// the input register, so the slave side stalls until that event drains.
// Reset: synchronous active-low; registers go to their defaults (interval 5, output
// enabled, 4 stable ticks, active-low pins), the scanner returns to idle.

module button_debounce_autorepeat (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // scan beats
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bdar_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [3:0] pin_levels
    // key events
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bdar_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // [2:0] key_code
    output logic                                m_axis_tuser,  // [0] event_type
    // register writes
    input  logic                                i_cfg_we,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [bdar_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import bdar_pkg::*;

    t_cfg   cfg;
    t_event evt;

    // Input register
    logic             r_in_valid;
    logic [PIN_W-1:0] r_in_pins;

    // Result register
    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_key;
    logic             r_out_type;

    logic out_free;
    logic step;
    logic in_take;

    // Result slot is free when empty or drained this cycle; the held beat
    // advances into the core only then, so an event never overwrites one.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bdar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdar_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pins  (r_in_pins),
        .i_cfg   (cfg),
        .o_event (evt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_take) begin
            r_in_pins <= s_axis_tdata[PIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= evt.valid;
        end
        if (out_free && evt.valid) begin
            r_out_key  <= evt.key_code;
            r_out_type <= evt.event_type;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W-KEY_W){1'b0}}, r_out_key};
    assign m_axis_tuser  = r_out_type;

endmodule
